// ----- sv/ata_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ata_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN = 24;
    localparam int NUM_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int PRESCALE = 14;
    localparam int ANG_FRAC = 16;
    localparam int VEC_W = 34;
    localparam int ANG_W = 26;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [8:0] deg_t;
    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    typedef struct packed {
        sample_t x;
        sample_t y;
        sample_t z;
        deg_t sx;
        deg_t sy;
        deg_t sz;
    } item_t;

    typedef struct packed {
        vec_t vx;
        vec_t vy;
        ang_t acc;
        ang_t offset;
        logic zero;
    } lane_t;

    function automatic ang_t atan_entry(input int i);
        logic [21:0] t;
        case (i)
            0: t = 22'd2949120;
            1: t = 22'd1740967;
            2: t = 22'd919879;
            3: t = 22'd466945;
            4: t = 22'd234379;
            5: t = 22'd117304;
            6: t = 22'd58666;
            7: t = 22'd29335;
            8: t = 22'd14668;
            9: t = 22'd7334;
            10: t = 22'd3667;
            11: t = 22'd1833;
            12: t = 22'd917;
            13: t = 22'd458;
            14: t = 22'd229;
            15: t = 22'd115;
            16: t = 22'd57;
            17: t = 22'd29;
            18: t = 22'd14;
            19: t = 22'd7;
            20: t = 22'd4;
            21: t = 22'd2;
            22: t = 22'd1;
            default: t = 22'd0;
        endcase
        return ang_t'({4'd0, t});
    endfunction

    function automatic deg_t scale_sample(input sample_t s);
        logic [22:0] u;
        logic [8:0] q;
        logic [13:0] r;
        u = 23'({~s[15], s[14:0]}) * 23'd90;
        q = u[22:14];
        r = u[13:0];
        if (r > 14'd8192 || (r == 14'd8192 && q[0]))
        begin
            q = q + 9'd1;
        end
        return deg_t'(q - 9'd180);
    endfunction

    function automatic lane_t lane_init(input sample_t a, input sample_t b);
        lane_t l;
        logic signed [16:0] aa;
        logic signed [16:0] bb;
        aa = 17'(a);
        bb = 17'(b);
        l.offset = '0;
        if (b < 0)
        begin
            l.offset = (a >= 0) ? ang_t'(180 <<< ANG_FRAC) : -ang_t'(180 <<< ANG_FRAC);
            aa = -aa;
            bb = -bb;
        end
        l.vx = vec_t'(bb) <<< PRESCALE;
        l.vy = vec_t'(aa) <<< PRESCALE;
        l.acc = '0;
        l.zero = (a == 0) && (b == 0);
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t l, input int i);
        lane_t n;
        vec_t xs;
        vec_t ys;
        n = l;
        xs = l.vx >>> i;
        ys = l.vy >>> i;
        if (l.vy > 0)
        begin
            n.vx = l.vx + ys;
            n.vy = l.vy - xs;
            n.acc = l.acc + atan_entry(i);
        end
        else
        begin
            n.vx = l.vx - ys;
            n.vy = l.vy + xs;
            n.acc = l.acc - atan_entry(i);
        end
        return n;
    endfunction

    function automatic deg_t lane_final(input lane_t l);
        ang_t s;
        ang_t r;
        s = l.acc + l.offset + ang_t'(1 <<< (ANG_FRAC - 1));
        r = s >>> ANG_FRAC;
        if (l.zero)
        begin
            return '0;
        end
        if (r > ang_t'(180))
        begin
            return deg_t'(180);
        end
        if (r < -ang_t'(180))
        begin
            return -deg_t'(180);
        end
        return deg_t'(r);
    endfunction

endpackage

`default_nettype wire

// ----- sv/accel_tilt_angles.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Accelerometer tilt angle engine.
// A request is issued by raising start with the six sample bytes while busy
// is low; it is taken at that rising edge. Each request yields one result,
// shown for one cycle with done high on the six result ports.
// The front stage joins bytes into samples and scales them, and a small
// queue passes the request to the back stage, a CORDIC pipeline with one
// register per iteration and three lanes for the three angles.
// A taken request passes the front register, the queue, the lane-init
// register, one register per iteration and the output register to done.
// One request is accepted every cycle; busy stays low in normal use and
// rises only if the queue nears full, which the pipeline never lets happen.
// The receiver cannot stall: each result is shown once and then dropped.
// Reset clears all valid flags and the queue; no request is in flight after.
module accel_tilt_angles (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic busy,
    input  wire logic [7:0] x_low,
    input  wire logic [7:0] x_high,
    input  wire logic [7:0] y_low,
    input  wire logic [7:0] y_high,
    input  wire logic [7:0] z_low,
    input  wire logic [7:0] z_high,
    output logic done,
    output ata_pkg::deg_t angle_x_over_y,
    output ata_pkg::deg_t angle_y_over_z,
    output ata_pkg::deg_t angle_z_over_x,
    output ata_pkg::deg_t scaled_x,
    output ata_pkg::deg_t scaled_y,
    output ata_pkg::deg_t scaled_z
);
    import ata_pkg::*;

    item_t f_item;
    item_t q_item;
    logic f_valid;
    logic q_not_empty;
    logic q_nearly_full;
    logic take;

    assign busy = q_nearly_full;
    assign take = start && !busy;

    ata_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take),
        .x_low(x_low), .x_high(x_high), .y_low(y_low), .y_high(y_high),
        .z_low(z_low), .z_high(z_high),
        .item(f_item), .item_valid(f_valid)
    );

    ata_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .push_data(f_item),
        .pop(q_not_empty), .pop_data(q_item),
        .not_empty(q_not_empty), .nearly_full(q_nearly_full)
    );

    ata_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_not_empty), .in_item(q_item),
        .out_valid(done),
        .angle_x_over_y(angle_x_over_y), .angle_y_over_z(angle_y_over_z),
        .angle_z_over_x(angle_z_over_x), .scaled_x(scaled_x),
        .scaled_y(scaled_y), .scaled_z(scaled_z)
    );

endmodule

`default_nettype wire

// ----- sv/ata_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ata_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic take,
    input  wire logic [7:0] x_low,
    input  wire logic [7:0] x_high,
    input  wire logic [7:0] y_low,
    input  wire logic [7:0] y_high,
    input  wire logic [7:0] z_low,
    input  wire logic [7:0] z_high,
    output ata_pkg::item_t item,
    output logic item_valid
);
    import ata_pkg::*;

    item_t item_reg;
    item_t item_next;
    logic valid_reg;

    always_comb
    begin
        item_next.x = sample_t'({x_high, x_low});
        item_next.y = sample_t'({y_high, y_low});
        item_next.z = sample_t'({z_high, z_low});
        item_next.sx = scale_sample(item_next.x);
        item_next.sy = scale_sample(item_next.y);
        item_next.sz = scale_sample(item_next.z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

// ----- sv/ata_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ata_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire ata_pkg::item_t push_data,
    input  wire logic pop,
    output ata_pkg::item_t pop_data,
    output logic not_empty,
    output logic nearly_full
);
    import ata_pkg::*;

    item_t mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg;
    logic [QUEUE_AW-1:0] rd_reg;
    logic [QUEUE_AW:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_reg];
    assign not_empty = cnt_reg != '0;
    assign nearly_full = cnt_reg >= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);

    property no_overflow;
        @(posedge clk) disable iff (!rst_n) push |-> (cnt_reg < (QUEUE_AW+1)'(QUEUE_DEPTH) || pop);
    endproperty
    assert property (no_overflow) else $error("queue overflow");

    property no_underflow;
        @(posedge clk) disable iff (!rst_n) pop |-> not_empty;
    endproperty
    assert property (no_underflow) else $error("queue underflow");

    property count_tracks;
        @(posedge clk) disable iff (!rst_n) (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1;
    endproperty
    assert property (count_tracks) else $error("queue count mismatch");

endmodule

`default_nettype wire

// ----- sv/ata_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ata_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire ata_pkg::item_t in_item,
    output logic out_valid,
    output ata_pkg::deg_t angle_x_over_y,
    output ata_pkg::deg_t angle_y_over_z,
    output ata_pkg::deg_t angle_z_over_x,
    output ata_pkg::deg_t scaled_x,
    output ata_pkg::deg_t scaled_y,
    output ata_pkg::deg_t scaled_z
);
    import ata_pkg::*;

    lane_t l0_reg [NUM_STAGES+1];
    lane_t l1_reg [NUM_STAGES+1];
    lane_t l2_reg [NUM_STAGES+1];
    deg_t sx_reg [NUM_STAGES+1];
    deg_t sy_reg [NUM_STAGES+1];
    deg_t sz_reg [NUM_STAGES+1];
    logic [NUM_STAGES:0] v_reg;
    logic ov_reg;
    deg_t o0_reg, o1_reg, o2_reg, o3_reg, o4_reg, o5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v_reg <= {v_reg[NUM_STAGES-1:0], in_valid};
            ov_reg <= v_reg[NUM_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        l0_reg[0] <= lane_init(in_item.x, in_item.y);
        l1_reg[0] <= lane_init(in_item.y, in_item.z);
        l2_reg[0] <= lane_init(in_item.z, in_item.x);
        sx_reg[0] <= in_item.sx;
        sy_reg[0] <= in_item.sy;
        sz_reg[0] <= in_item.sz;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            l0_reg[i+1] <= lane_step(l0_reg[i], i);
            l1_reg[i+1] <= lane_step(l1_reg[i], i);
            l2_reg[i+1] <= lane_step(l2_reg[i], i);
            sx_reg[i+1] <= sx_reg[i];
            sy_reg[i+1] <= sy_reg[i];
            sz_reg[i+1] <= sz_reg[i];
        end
        o0_reg <= lane_final(l0_reg[NUM_STAGES]);
        o1_reg <= lane_final(l1_reg[NUM_STAGES]);
        o2_reg <= lane_final(l2_reg[NUM_STAGES]);
        o3_reg <= sx_reg[NUM_STAGES];
        o4_reg <= sy_reg[NUM_STAGES];
        o5_reg <= sz_reg[NUM_STAGES];
    end

    assign out_valid = ov_reg;
    assign angle_x_over_y = o0_reg;
    assign angle_y_over_z = o1_reg;
    assign angle_z_over_x = o2_reg;
    assign scaled_x = o3_reg;
    assign scaled_y = o4_reg;
    assign scaled_z = o5_reg;

    property valid_follows;
        @(posedge clk) disable iff (!rst_n) v_reg[NUM_STAGES] |=> out_valid;
    endproperty
    assert property (valid_follows) else $error("result strobe lost");

    property angle_range;
        @(posedge clk) disable iff (!rst_n)
            out_valid |-> (angle_x_over_y <= 9'sd180 && angle_x_over_y >= -9'sd180);
    endproperty
    assert property (angle_range) else $error("angle out of range");

    property scaled_range;
        @(posedge clk) disable iff (!rst_n)
            out_valid |-> (scaled_x <= 9'sd180 && scaled_x >= -9'sd180);
    endproperty
    assert property (scaled_range) else $error("scaled value out of range");

endmodule

`default_nettype wire

// ----- sim/tb_accel_tilt_angles.sv -----
`timescale 1ns / 1ps

module tb_accel_tilt_angles;

    import ata_pkg::*;

    typedef struct packed {
        deg_t xy;
        deg_t yz;
        deg_t zx;
        deg_t sx;
        deg_t sy;
        deg_t sz;
    } tilt_t;

    typedef struct packed {
        logic lit;
        logic [7:0] xl;
        logic [7:0] xh;
        logic [7:0] yl;
        logic [7:0] yh;
        logic [7:0] zl;
        logic [7:0] zh;
        tilt_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 13;
    localparam int RANDOM_ITEMS = 1500;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    localparam longint ATAN_LUT [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [7:0] x_low = '0;
    logic [7:0] x_high = '0;
    logic [7:0] y_low = '0;
    logic [7:0] y_high = '0;
    logic [7:0] z_low = '0;
    logic [7:0] z_high = '0;
    logic done;
    deg_t angle_x_over_y;
    deg_t angle_y_over_z;
    deg_t angle_z_over_x;
    deg_t scaled_x;
    deg_t scaled_y;
    deg_t scaled_z;

    tilt_t cur_want = '0;
    tilt_t pending_tilts [$];
    int mismatches = 0;
    int quiet_cycles = 0;
    dir_row_t dir_tab [DIR_ROWS];

    accel_tilt_angles dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .x_low(x_low),
        .x_high(x_high),
        .y_low(y_low),
        .y_high(y_high),
        .z_low(z_low),
        .z_high(z_high),
        .done(done),
        .angle_x_over_y(angle_x_over_y),
        .angle_y_over_z(angle_y_over_z),
        .angle_z_over_x(angle_z_over_x),
        .scaled_x(scaled_x),
        .scaled_y(scaled_y),
        .scaled_z(scaled_z)
    );

    always #5 clk = ~clk;

    function automatic int tilt_angle(input int a_in, input int b_in);
        longint a;
        longint b;
        longint vx;
        longint vy;
        longint nx;
        longint acc;
        longint ofs;
        longint r;
        a = a_in;
        b = b_in;
        acc = 0;
        ofs = 0;
        if (a == 0 && b == 0)
        begin
            return 0;
        end
        if (b < 0)
        begin
            ofs = (a >= 0) ? 180 * 65536 : -180 * 65536;
            a = -a;
            b = -b;
        end
        vx = b * 16384;
        vy = a * 16384;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (vy > 0)
            begin
                nx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                acc = acc + ATAN_LUT[i];
            end
            else
            begin
                nx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                acc = acc - ATAN_LUT[i];
            end
            vx = nx;
        end
        r = (acc + ofs + 32768) >>> 16;
        if (r > 180)
        begin
            r = 180;
        end
        if (r < -180)
        begin
            r = -180;
        end
        return int'(r);
    endfunction

    function automatic int scale_to_deg(input int s);
        int u;
        int q;
        int rem;
        u = (s + 32768) * 90;
        q = u / 16384;
        rem = u % 16384;
        if (rem > 8192 || (rem == 8192 && (q % 2) == 1))
        begin
            q = q + 1;
        end
        return q - 180;
    endfunction

    function automatic tilt_t predict_tilt(input logic [7:0] xl, input logic [7:0] xh,
                                           input logic [7:0] yl, input logic [7:0] yh,
                                           input logic [7:0] zl, input logic [7:0] zh);
        tilt_t t;
        int xs;
        int ys;
        int zs;
        xs = int'($signed({xh, xl}));
        ys = int'($signed({yh, yl}));
        zs = int'($signed({zh, zl}));
        t.xy = deg_t'(tilt_angle(xs, ys));
        t.yz = deg_t'(tilt_angle(ys, zs));
        t.zx = deg_t'(tilt_angle(zs, xs));
        t.sx = deg_t'(scale_to_deg(xs));
        t.sy = deg_t'(scale_to_deg(ys));
        t.sz = deg_t'(scale_to_deg(zs));
        return t;
    endfunction

    function automatic dir_row_t mk_row(input logic lit, input logic [15:0] xv,
                                        input logic [15:0] yv, input logic [15:0] zv,
                                        input int xy, input int yz, input int zx,
                                        input int sx, input int sy, input int sz);
        dir_row_t r;
        r.lit = lit;
        {r.xh, r.xl} = xv;
        {r.yh, r.yl} = yv;
        {r.zh, r.zl} = zv;
        r.want = {deg_t'(xy), deg_t'(yz), deg_t'(zx), deg_t'(sx), deg_t'(sy), deg_t'(sz)};
        return r;
    endfunction

    task automatic send_request(input logic [7:0] xl, input logic [7:0] xh,
                                input logic [7:0] yl, input logic [7:0] yh,
                                input logic [7:0] zl, input logic [7:0] zh,
                                input tilt_t want);
        @(negedge clk);
        start = 1'b1;
        x_low = xl;
        x_high = xh;
        y_low = yl;
        y_high = yh;
        z_low = zl;
        z_high = zh;
        cur_want = want;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_cycles(input int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [7:0] rand_high();
        case ($urandom_range(0, 7))
            0: return 8'h7F;
            1: return 8'h80;
            2: return 8'hFF;
            3: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        tilt_t got;
        tilt_t exp_t;
        deg_t got_v [6];
        deg_t exp_v [6];
        string names [6];
        names = '{"angle_x_over_y", "angle_y_over_z", "angle_z_over_x",
                  "scaled_x", "scaled_y", "scaled_z"};
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (start && !busy)
            begin
                pending_tilts.push_back(cur_want);
                quiet_cycles = 0;
            end
            if (done)
            begin
                quiet_cycles = 0;
                got = {angle_x_over_y, angle_y_over_z, angle_z_over_x,
                       scaled_x, scaled_y, scaled_z};
                if (pending_tilts.size() == 0)
                begin
                    $error("Result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    exp_t = pending_tilts.pop_front();
                    got_v = '{got.xy, got.yz, got.zx, got.sx, got.sy, got.sz};
                    exp_v = '{exp_t.xy, exp_t.yz, exp_t.zx, exp_t.sx, exp_t.sy, exp_t.sz};
                    for (int k = 0; k < 6; k++)
                    begin
                        if (got_v[k] !== exp_v[k])
                        begin
                            $error("%s: expected %0d, got %0d", names[k], exp_v[k], got_v[k]);
                            mismatches++;
                        end
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int burst;
        logic [7:0] b [6];
        dir_tab[0] = mk_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 0);
        dir_tab[1] = mk_row(1'b1, 16'h7FFF, 16'h0000, 16'h0000, 90, 0, 0, 180, 0, 0);
        dir_tab[2] = mk_row(1'b1, 16'h8000, 16'h0000, 16'h0000, -90, 0, 180, -180, 0, 0);
        dir_tab[3] = mk_row(1'b1, 16'h0000, 16'h7FFF, 16'h0000, 0, 90, 0, 0, 180, 0);
        dir_tab[4] = mk_row(1'b1, 16'h0000, 16'h8000, 16'h0000, 180, -90, 0, 0, -180, 0);
        dir_tab[5] = mk_row(1'b1, 16'h0000, 16'h0000, 16'h7FFF, 0, 0, 90, 0, 0, 180);
        dir_tab[6] = mk_row(1'b1, 16'h0000, 16'h0000, 16'h8000, 0, 180, -90, 0, 0, -180);
        dir_tab[7] = mk_row(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 0, 0);
        dir_tab[8] = mk_row(1'b0, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0);
        dir_tab[9] = mk_row(1'b0, 16'h9000, 16'h3000, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        dir_tab[10] = mk_row(1'b0, 16'h0001, 16'hFFFF, 16'h0100, 0, 0, 0, 0, 0, 0);
        dir_tab[11] = mk_row(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        dir_tab[12] = mk_row(1'b0, 16'h5A5A, 16'hA5A5, 16'hC3C3, 0, 0, 0, 0, 0, 0);

        repeat (8)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            send_request(dir_tab[r].xl, dir_tab[r].xh, dir_tab[r].yl, dir_tab[r].yh,
                         dir_tab[r].zl, dir_tab[r].zh,
                         dir_tab[r].lit ? dir_tab[r].want
                                        : predict_tilt(dir_tab[r].xl, dir_tab[r].xh,
                                                       dir_tab[r].yl, dir_tab[r].yh,
                                                       dir_tab[r].zl, dir_tab[r].zh));
            if (r % 4 == 3)
            begin
                idle_cycles($urandom_range(1, 3));
            end
        end

        burst = $urandom_range(1, 40);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            for (int k = 0; k < 6; k++)
            begin
                b[k] = (k % 2 == 1) ? rand_high() : 8'($urandom);
            end
            if ($urandom_range(0, 15) == 0)
            begin
                b[2 * $urandom_range(0, 2)] = 8'h00;
            end
            send_request(b[0], b[1], b[2], b[3], b[4], b[5],
                         predict_tilt(b[0], b[1], b[2], b[3], b[4], b[5]));
            burst--;
            if (burst == 0)
            begin
                idle_cycles($urandom_range(1, 8));
                burst = $urandom_range(1, 40);
            end
        end
        @(negedge clk);
        start = 1'b0;

        while (pending_tilts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
